// ===== rtl/text_console_writer_assert.svh =====
// ----------------------------------------------------------------------------
// text console writer assertion macros
// shared concurrent assertion forms, clocked on the rising edge, reset masked
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// same-cycle implication
`define TCW_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TCW_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg
// geometry, codes, beat types and control bundles of the text console writer
// ----------------------------------------------------------------------------
package tcw_pkg;

  // screen geometry
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = ROWS * COLUMNS;
  localparam int ADDR_W  = (CELLS > 1) ? $clog2(CELLS) : 1;

  // field widths
  localparam int KIND_W = 3;
  localparam int CHAR_W = 8;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CLR_W  = 4;
  localparam int ATTR_W = 8;
  localparam int CELL_W = 16;

  // command kinds
  localparam logic [KIND_W-1:0] KIND_PUT_CHAR = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SET_CUR  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_PUT_AT   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CLEAR    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_READ     = 3'd4;

  localparam logic [CHAR_W-1:0] NEWLINE = 8'h0A;

  // input beat
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CHAR_W-1:0] character;
    logic [COL_W-1:0]  column;
    logic [ROW_W-1:0]  row;
    logic [CLR_W-1:0]  background;
    logic [CLR_W-1:0]  foreground;
  } tcw_in_t;

  // output beat
  typedef struct packed {
    logic [CELL_W-1:0] cell_data;
    logic [COL_W-1:0]  cursor_column;
    logic [ROW_W-1:0]  cursor_row;
  } tcw_out_t;

  // controller to datapath
  typedef struct packed {
    logic load_item;
    logic exec;
    logic sweep_start;
    logic sweep_copy;
    logic sweep_step;
    logic capture_read;
    logic load_out;
  } tcw_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              need_scroll;
    logic              sweep_last;
    logic              out_busy;
  } tcw_status_t;

  // linear store address of an in-range position
  function automatic logic [ADDR_W-1:0] cell_addr(logic [ROW_W-1:0] r, logic [COL_W-1:0] c);
    cell_addr = ADDR_W'(int'(r) * COLUMNS + int'(c));
  endfunction

endpackage

// ===== rtl/tcw_ctrl.sv =====
// ----------------------------------------------------------------------------
// tcw_ctrl
// sequencer: accept, execute, store sweeps, cell read and result hand-off
// ----------------------------------------------------------------------------
`include "text_console_writer_assert.svh"

module tcw_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output tcw_pkg::tcw_cmd_t   cmd_o,
  input  tcw_pkg::tcw_status_t status_i
);
  import tcw_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_SWEEP  = 3'd2;
  localparam logic [2:0] S_FLUSH  = 3'd3;
  localparam logic [2:0] S_READ   = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  logic [2:0] state_q, state_d;
  logic       init_q, init_d;

  // state register, reset starts the clearing sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_SWEEP;
      init_q  <= 1'b1;
    end else begin
      state_q <= state_d;
      init_q  <= init_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d = state_q;
    init_d  = init_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        case (status_i.kind)
          KIND_PUT_CHAR: begin
            if (status_i.need_scroll) begin
              cmd_o.sweep_start = 1'b1;
              cmd_o.sweep_copy  = 1'b1;
              state_d           = S_SWEEP;
            end else begin
              state_d = S_FINISH;
            end
          end
          KIND_CLEAR: begin
            cmd_o.sweep_start = 1'b1;
            state_d           = S_SWEEP;
          end
          KIND_READ: state_d = S_READ;
          default:   state_d = S_FINISH;
        endcase
      end
      S_SWEEP: begin
        cmd_o.sweep_step = 1'b1;
        if (status_i.sweep_last) begin
          state_d = S_FLUSH;
        end
      end
      S_FLUSH: begin
        // last store write drains here
        if (init_q) begin
          init_d  = 1'b0;
          state_d = S_IDLE;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_READ: begin
        cmd_o.capture_read = 1'b1;
        state_d            = S_FINISH;
      end
      S_FINISH: begin
        if (!status_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);

  // checks
  `TCW_ASSERT_NEXT(a_sweep_ends_in_flush, clk_i, rst_ni,
    (state_q == S_SWEEP) && status_i.sweep_last, state_q == S_FLUSH, "sweep did not flush")
  `TCW_ASSERT_SAME(a_no_accept_during_init, clk_i, rst_ni,
    init_q, !in_ready_o, "input taken before the store was cleared")

endmodule

// ===== rtl/tcw_datapath.sv =====
// ----------------------------------------------------------------------------
// tcw_datapath
// text store, cursor, color register, sweep pipeline and result register
// ----------------------------------------------------------------------------
`include "text_console_writer_assert.svh"

module tcw_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tcw_pkg::tcw_cmd_t             cmd_i,
  output tcw_pkg::tcw_status_t          status_o,
  input  tcw_pkg::tcw_in_t              in_data_i,
  input  logic                          cfg_valid_i,
  input  logic [tcw_pkg::ATTR_W-1:0]    cfg_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output tcw_pkg::tcw_out_t             out_data_o
);
  import tcw_pkg::*;

  // registers
  tcw_in_t           item_q;
  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [ATTR_W-1:0] color_q;
  logic [CELL_W-1:0] cell_q;
  logic [ADDR_W-1:0] cnt_q;
  logic              copy_q;
  logic              pend_we_q;
  logic [ADDR_W-1:0] pend_addr_q;
  logic              pend_zero_q;
  logic              out_valid_q;
  tcw_out_t          out_q;

  // store
  logic [CELL_W-1:0] mem [CELLS];
  logic [CELL_W-1:0] rdata_q;

  // decode
  logic              pos_ok, is_nl, line_end, last_row, next_line, sweep_src;
  logic              ex_we, we, rd_en;
  logic [ADDR_W-1:0] ex_addr, waddr, rd_addr;
  logic [CELL_W-1:0] ex_data, wdata;

  assign pos_ok    = (int'(item_q.column) < COLUMNS) && (int'(item_q.row) < ROWS);
  assign is_nl     = (item_q.character == NEWLINE);
  assign line_end  = (int'(col_q) == COLUMNS - 1);
  assign last_row  = (int'(row_q) == ROWS - 1);
  assign next_line = is_nl || line_end;
  assign sweep_src = copy_q && (int'(cnt_q) < CELLS - COLUMNS);

  assign status_o.kind        = item_q.kind;
  assign status_o.need_scroll = next_line && last_row;
  assign status_o.sweep_last  = (int'(cnt_q) == CELLS - 1);
  assign status_o.out_busy    = out_valid_q && !out_ready_i;

  // cursor update and direct writes
  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    ex_we   = 1'b0;
    ex_addr = cell_addr(row_q, col_q);
    ex_data = {color_q, item_q.character};
    if (cmd_i.exec) begin
      case (item_q.kind)
        KIND_PUT_CHAR: begin
          ex_we = !is_nl;
          if (next_line) begin
            col_d = '0;
            if (!last_row) begin
              row_d = row_q + 1'b1;
            end
          end else begin
            col_d = col_q + 1'b1;
          end
        end
        KIND_SET_CUR: begin
          col_d = (int'(item_q.column) < COLUMNS) ? item_q.column : COL_W'(COLUMNS - 1);
          row_d = (int'(item_q.row) < ROWS) ? item_q.row : ROW_W'(ROWS - 1);
        end
        KIND_PUT_AT: begin
          ex_we   = pos_ok;
          ex_addr = cell_addr(item_q.row, item_q.column);
          ex_data = {item_q.background, item_q.foreground, item_q.character};
        end
        default: ;
      endcase
    end
  end

  // read port select
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = cell_addr(item_q.row, item_q.column);
    if (cmd_i.exec && (item_q.kind == KIND_READ) && pos_ok) begin
      rd_en = 1'b1;
    end
    if (cmd_i.sweep_step && sweep_src) begin
      rd_en   = 1'b1;
      rd_addr = ADDR_W'(int'(cnt_q) + COLUMNS);
    end
  end

  // write port select, delayed sweep write wins
  assign we    = pend_we_q || ex_we;
  assign waddr = pend_we_q ? pend_addr_q : ex_addr;
  assign wdata = pend_we_q ? (pend_zero_q ? '0 : rdata_q) : ex_data;

  // store access
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      color_q     <= '0;
      cnt_q       <= '0;
      copy_q      <= 1'b0;
      pend_we_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (cfg_valid_i) begin
        color_q <= cfg_data_i;
      end
      if (cmd_i.sweep_start) begin
        cnt_q  <= '0;
        copy_q <= cmd_i.sweep_copy;
      end else if (cmd_i.sweep_step) begin
        cnt_q <= cnt_q + 1'b1;
      end
      pend_we_q <= cmd_i.sweep_step;
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_q <= in_data_i;
    end
    pend_addr_q <= cnt_q;
    pend_zero_q <= !sweep_src;
    if (cmd_i.exec) begin
      cell_q <= '0;
    end else if (cmd_i.capture_read) begin
      cell_q <= pos_ok ? rdata_q : '0;
    end
    if (cmd_i.load_out) begin
      out_q.cell_data     <= cell_q;
      out_q.cursor_column <= col_q;
      out_q.cursor_row    <= row_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // checks
  `TCW_ASSERT_SAME(a_cursor_in_range, clk_i, rst_ni,
    1'b1, (int'(col_q) < COLUMNS) && (int'(row_q) < ROWS), "cursor left the screen")
  `TCW_ASSERT_SAME(a_one_writer, clk_i, rst_ni,
    pend_we_q, !ex_we, "sweep write collides with a direct write")
  `TCW_ASSERT_SAME(a_no_result_overrun, clk_i, rst_ni,
    cmd_i.load_out, !(out_valid_q && !out_ready_i), "result loaded over a pending beat")

endmodule

// ===== rtl/text_console_writer.sv =====
// ----------------------------------------------------------------------------
// text_console_writer
// text-mode console engine: 80x25 cell store with cursor, scroll and clear
// ----------------------------------------------------------------------------
// One command is handled at a time. Put-char, set-cursor, put-at-position and
// unused kinds pass through accept, execute and result load; read-cell adds a
// step for the registered store read before the result load. A put-char that
// scrolls and the clear command walk the whole store, one cell per cycle,
// through its single write port (the scroll also reads each source cell
// through the single read port), then drain the last write. After reset the
// store is cleared by such a pass, during which no command is taken.
// The color register can be written at any time; it is sampled by put-char.
// A finished result waits in an output register and does not block the next
// command from being accepted and executed.
// ----------------------------------------------------------------------------
module text_console_writer (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  tcw_pkg::tcw_in_t           in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output tcw_pkg::tcw_out_t          out_data_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [tcw_pkg::ATTR_W-1:0] cfg_data_i
);
  import tcw_pkg::*;

  tcw_cmd_t    cmd;
  tcw_status_t status;

  // color writes are always taken
  assign cfg_ready_o = 1'b1;

  // sequencer
  tcw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  // store and cursor
  tcw_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
